>>> hdl/forbp_pkg.sv
// Package for the frame-of-reference bit packer: widths, register codes, queue entry type.
`default_nettype none
package forbp_pkg;

  localparam int VALUE_W = 64;
  localparam int WIDTH_W = 7;
  localparam int BYTE_W  = 8;
  localparam int ACC_W   = VALUE_W + BYTE_W - 1;  // residue of up to 7 bits plus one code
  localparam int CNT_W   = 7;                     // holds 0..71
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_VALUE = 1'b0,
    CFG_CODE_WIDTH = 1'b1
  } cfg_idx_t;

  // One classified item waiting for the packer.
  typedef struct packed {
    logic [VALUE_W-1:0] code;    // masked to the width, higher bits zero
    logic [WIDTH_W-1:0] width;   // effective width, 1..64
    logic               is_null;
    logic               eob;
  } entry_t;

endpackage
`default_nettype wire

>>> hdl/frame_of_reference_bit_packer.sv
// Top level of the frame-of-reference bit packer: config registers, front end, queue, packer.
//
// Usage:
//   in_*   : one signed 64-bit value per item on in_tdata, in_tuser = null flag,
//            in_tlast = end of block. A null item adds no code.
//   out_*  : one packed byte per item on out_tdata, LSB first; out_tlast marks the final
//            byte of a block (a padded byte if residue bits remain at block end).
//   cfg_*  : cfg_index 0 = base value, 1 = code width (low 7 bits of cfg_data); write only
//            while the block is idle. cfg_ready is always high.
// Flow: an item enters the two-entry queue when it is accepted; the packer loads it into
//   the residue once it is not busy, and each completed byte then moves from the residue
//   into the output register.
// Throughput: the packer either loads a code or releases a byte, never both at once. It
//   releases one byte per cycle while out_tready does not stall it, takes a new code only
//   once no full byte is pending, and also releases the padded byte at block end. The byte drain sets the rate.
// Reset: residue cleared, queue empty, base value = 0, code width = 1.
// Stall: when out_tready is low the output register holds its byte, the packer stops,
//   the queue fills and in_tready drops once both entries are taken.
`default_nettype none
module frame_of_reference_bit_packer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  input  wire logic [forbp_pkg::VALUE_W-1:0]   in_tdata,   // [63:0] value
  input  wire logic                            in_tuser,   // [0] is_null
  input  wire logic                            in_tlast,   // end_of_block
  // result channel
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  output      logic [forbp_pkg::BYTE_W-1:0]    out_tdata,  // [7:0] packed_byte
  output      logic                            out_tlast,  // last_byte
  // configuration write channel
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [forbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [forbp_pkg::VALUE_W-1:0]   cfg_data
);
  import forbp_pkg::*;

  logic [VALUE_W-1:0] base_value_r;
  logic [WIDTH_W-1:0] code_width_r;
  entry_t             front_entry;
  entry_t             q_entry;
  logic               q_valid;
  logic               q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_value_r <= '0;
      code_width_r <= WIDTH_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BASE_VALUE: base_value_r <= cfg_data;
        CFG_CODE_WIDTH: code_width_r <= cfg_data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  forbp_front u_front (
    .value      (in_tdata),
    .is_null    (in_tuser),
    .eob        (in_tlast),
    .base_value (base_value_r),
    .code_width (code_width_r),
    .entry      (front_entry)
  );

  forbp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_ready (in_tready),
    .wr_entry (front_entry),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_entry (q_entry)
  );

  forbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_entry    (q_entry),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

>>> hdl/forbp_front.sv
// Front end: subtracts the base value and masks the difference to the code width.
`default_nettype none
module forbp_front (
  input  wire logic [forbp_pkg::VALUE_W-1:0] value,
  input  wire logic                          is_null,
  input  wire logic                          eob,
  input  wire logic [forbp_pkg::VALUE_W-1:0] base_value,
  input  wire logic [forbp_pkg::WIDTH_W-1:0] code_width,
  output forbp_pkg::entry_t                  entry
);
  import forbp_pkg::*;

  logic [WIDTH_W-1:0] eff_w;
  logic [VALUE_W-1:0] mask;
  logic [VALUE_W-1:0] diff;

  always_comb begin
    if (code_width == '0) begin
      eff_w = WIDTH_W'(1);
    end else if (code_width > WIDTH_W'(VALUE_W)) begin
      eff_w = WIDTH_W'(VALUE_W);
    end else begin
      eff_w = code_width;
    end
  end

  always_comb begin
    if (eff_w == WIDTH_W'(VALUE_W)) begin
      mask = '1;
    end else begin
      mask = ~({VALUE_W{1'b1}} << eff_w[5:0]);
    end
  end

  assign diff = value - base_value;

  always_comb begin
    entry.code    = diff & mask;
    entry.width   = eff_w;
    entry.is_null = is_null;
    entry.eob     = eob;
  end

endmodule
`default_nettype wire

>>> hdl/forbp_queue.sv
// Two-entry queue between the front end and the packer.
`default_nettype none
module forbp_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_valid,
  output      logic              wr_ready,
  input  wire forbp_pkg::entry_t wr_entry,
  output      logic              rd_valid,
  input  wire logic              rd_ready,
  output      forbp_pkg::entry_t rd_entry
);
  import forbp_pkg::*;

  entry_t       mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;
  logic         do_wr, do_rd;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_entry = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule
`default_nettype wire

>>> hdl/forbp_back.sv
// Packer: appends codes to the residue; drains a byte per cycle to the output register unless stalled.
`default_nettype none
module forbp_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  output      logic                         q_ready,
  input  wire forbp_pkg::entry_t            q_entry,
  output      logic                         out_tvalid,
  input  wire logic                         out_tready,
  output      logic [forbp_pkg::BYTE_W-1:0] out_tdata,
  output      logic                         out_tlast
);
  import forbp_pkg::*;

  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              eob_r, eob_nxt;
  logic              busy;
  logic              load;
  logic              emit;
  logic              emit_last;
  logic              ovalid_r, ovalid_nxt;
  logic [BYTE_W-1:0] odata_r, odata_nxt;
  logic              olast_r, olast_nxt;

  // Busy while a full byte is pending, or a partial byte must be flushed at block end.
  assign busy      = (cnt_r >= CNT_W'(BYTE_W)) || (eob_r && (cnt_r != '0));
  assign q_ready   = !busy;
  assign load      = q_valid && !busy;
  assign emit      = busy && (!ovalid_r || out_tready);
  assign emit_last = eob_r && (cnt_r <= CNT_W'(BYTE_W));

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    eob_nxt = eob_r;
    if (load) begin
      eob_nxt = q_entry.eob;
      if (!q_entry.is_null) begin
        acc_nxt = acc_r | (ACC_W'(q_entry.code) << cnt_r[2:0]);
        cnt_nxt = cnt_r + q_entry.width;
      end
    end else if (emit) begin
      acc_nxt = acc_r >> BYTE_W;
      cnt_nxt = (cnt_r >= CNT_W'(BYTE_W)) ? cnt_r - CNT_W'(BYTE_W) : '0;
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      odata_nxt  = acc_r[BYTE_W-1:0];
      olast_nxt  = emit_last;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      cnt_r    <= '0;
      eob_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      eob_r    <= eob_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

`ifndef SYNTHESIS
  // Bits from bit 7 upward, above the largest residue, stay clear whenever a new code may be merged in.
  a_residue_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (acc_r[ACC_W-1:BYTE_W-1] == '0))
    else $error("residue has stray bits above its count");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> (cnt_r == '0))
    else $error("residue not empty after the last byte of a block");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(ACC_W))
    else $error("bit count out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_tready) |=> (ovalid_r && $stable(odata_r) && $stable(olast_r)))
    else $error("output item changed while stalled");
`endif

endmodule
`default_nettype wire
